// File: rtl/ctm_pkg.sv
// Shared types and constants for the counter/time map table.
package ctm_pkg;

    localparam int DEPTH            = 128;
    localparam int AW               = 7;
    localparam int CW               = 8;
    localparam int QW               = 96;
    localparam int UNITS_SHIFT      = 30;
    localparam int UNITS_PER_SECOND = 1 << UNITS_SHIFT;

    localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;

    typedef enum logic [2:0] {
        CMD_ADD    = 3'd0,
        CMD_EXPIRE = 3'd1,
        CMD_C2T    = 3'd2,
        CMD_T2C    = 3'd3,
        CMD_CLEAR  = 3'd4,
        CMD_READ   = 3'd5
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_BAD_RATE  = 3'd2,
        ST_NOT_MONO  = 3'd3,
        ST_FULL      = 3'd4,
        ST_BAD_INDEX = 3'd5
    } t_status;

    typedef struct packed {
        logic [63:0] tim;
        logic [63:0] cnt;
        logic [31:0] rate;
    } t_entry;

    typedef struct packed {
        logic          wr_en;
        logic [AW-1:0] wr_addr;
        t_entry        wr_data;
        logic [AW-1:0] rd_addr;
    } t_mem_req;

    typedef struct packed {
        logic        start;
        logic        shr;
        logic [63:0] mag;
        logic [31:0] mul;
        logic [31:0] div;
    } t_md_req;

    typedef struct packed {
        logic          done;
        logic [QW-1:0] quot;
    } t_md_rsp;

endpackage

// File: rtl/ctm_mem.sv
// Anchor table memory: one write port, one registered read port.
module ctm_mem (
    input  logic              i_clk,
    input  ctm_pkg::t_mem_req i_req,
    output ctm_pkg::t_entry   o_rdata
);

    ctm_pkg::t_entry r_mem [ctm_pkg::DEPTH];
    ctm_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        r_rdata <= r_mem[i_req.rd_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/ctm_md.sv
// Multiply then divide unit: floor(mag * mul / div) one bit per cycle, or a shift by the time unit.
module ctm_md (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ctm_pkg::t_md_req i_req,
    output ctm_pkg::t_md_rsp o_rsp
);

    typedef enum logic [2:0] {S_IDLE, S_LO, S_HI, S_SUM, S_DIV} t_state;

    t_state                   r_state;
    logic                     r_shr;
    logic [63:0]              r_mag;
    logic [31:0]              r_mul;
    logic [31:0]              r_div;
    logic [63:0]              r_p0;
    logic [63:0]              r_p1;
    logic [ctm_pkg::QW-1:0]   r_dq;
    logic [31:0]              r_rem;
    logic [6:0]               r_step;
    logic                     r_done;

    logic [31:0]            w_a;
    logic [63:0]            w_prod;
    logic [ctm_pkg::QW-1:0] w_sum;
    logic [32:0]            w_trial;
    logic [32:0]            w_sub;
    logic                   w_ge;

    always_comb begin
        w_a     = (r_state == S_LO) ? r_mag[31:0] : r_mag[63:32];
        w_prod  = {32'd0, w_a} * {32'd0, r_mul};
        w_sum   = {32'd0, r_p0} + {r_p1, 32'd0};
        w_trial = {r_rem, r_dq[ctm_pkg::QW-1]};
        w_ge    = w_trial >= {1'b0, r_div};
        w_sub   = w_trial - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_shr   <= i_req.shr;
                        r_mag   <= i_req.mag;
                        r_mul   <= i_req.mul;
                        r_div   <= i_req.div;
                        r_state <= S_LO;
                    end
                end
                S_LO: begin
                    r_p0    <= w_prod;
                    r_state <= S_HI;
                end
                S_HI: begin
                    r_p1    <= w_prod;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    if (r_shr) begin
                        r_dq    <= w_sum >> ctm_pkg::UNITS_SHIFT;
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_dq    <= w_sum;
                        r_rem   <= 32'd0;
                        r_step  <= 7'd0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem  <= w_ge ? w_sub[31:0] : w_trial[31:0];
                    r_dq   <= {r_dq[ctm_pkg::QW-2:0], w_ge};
                    r_step <= r_step + 7'd1;
                    if (r_step == 7'(ctm_pkg::QW - 1)) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_dq;

endmodule

// File: rtl/counter_time_map_table_unit.sv
// Top level: anchor ring table mapping sample counters to timestamps and back.
//
//   channel   handshake            payload
//   request   start / busy         i_cmd, i_anchor_*, i_query_*, i_entry_index
//   result    o_done (one cycle)   o_status, o_result_*, o_entry_*, o_entry_count
//
// Add, clear, read entry and unused codes finish from idle or after one table read.
// Expire walks the entries from the oldest, one table read per cycle, until the break.
// Counter to time scans entries from the newest, then runs a multiply
// then a 96-step divide that retires one quotient bit per cycle.
// Time to counter scans entries the same way, then runs a multiply and a shift.
// Reset empties the table at once; stored entries need no clearing.
// The result strobe cannot be stalled; busy drops in the strobe cycle.
module counter_time_map_table_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic [2:0]         i_cmd,
    input  logic signed [63:0] i_anchor_time,
    input  logic [63:0]        i_anchor_counter,
    input  logic [31:0]        i_anchor_rate,
    input  logic [63:0]        i_query_counter,
    input  logic signed [63:0] i_query_time,
    input  logic [6:0]         i_entry_index,
    output logic               busy,
    output logic               o_done,
    output logic [2:0]         o_status,
    output logic signed [63:0] o_result_time,
    output logic [63:0]        o_result_counter,
    output logic signed [63:0] o_entry_time_out,
    output logic [63:0]        o_entry_counter_out,
    output logic [31:0]        o_entry_rate_out,
    output logic [7:0]         o_entry_count
);

    typedef enum logic [2:0] {
        S_IDLE, S_ADD_CHK, S_EXP, S_KEY0, S_SCAN, S_PREP, S_MDW, S_READ
    } t_state;

    localparam logic [31:0] UNITS = 32'(ctm_pkg::UNITS_PER_SECOND);

    t_state                     r_state;
    ctm_pkg::t_cmd              r_cmd;
    logic [63:0]                r_time;
    logic [63:0]                r_cnt_in;
    logic [31:0]                r_rate_in;
    logic [63:0]                r_qc;
    logic [63:0]                r_qt;
    logic [ctm_pkg::AW-1:0]     r_oldest;
    logic [ctm_pkg::CW-1:0]     r_count;
    logic [ctm_pkg::AW-1:0]     r_j;
    logic [63:0]                r_prev;
    ctm_pkg::t_entry            r_ent;
    logic                       r_neg;
    ctm_pkg::t_md_req           r_md;
    logic                       r_done;
    ctm_pkg::t_status           r_status;
    logic [63:0]                r_rtime;
    logic [63:0]                r_rcount;
    logic [63:0]                r_etime;
    logic [63:0]                r_ecount;
    logic [31:0]                r_erate;

    ctm_pkg::t_mem_req          mem_req;
    ctm_pkg::t_entry            w_rd;
    ctm_pkg::t_md_rsp           md_rsp;

    logic                   w_accept;
    logic [ctm_pkg::AW-1:0] w_newest;
    logic [ctm_pkg::AW-1:0] w_tail;
    logic                   w_dup;
    logic                   w_early;
    logic                   w_add_ok;
    logic [63:0]            w_key;
    logic [63:0]            w_q;
    logic                   w_brk;
    logic [63:0]            w_diff;
    logic [63:0]            w_a;
    logic [63:0]            w_b;
    logic [63:0]            w_tb;
    logic [63:0]            w_d;
    logic                   w_ovf;
    logic [63:0]            w_conv;

    ctm_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (w_rd)
    );

    ctm_md u_md (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_md),
        .o_rsp   (md_rsp)
    );

    always_comb begin
        w_accept = start && !busy;
        w_newest = r_oldest + ctm_pkg::AW'(r_count - 8'd1);
        w_tail   = r_oldest + ctm_pkg::AW'(r_count);
        w_dup    = (w_rd.tim == r_time) && (w_rd.cnt == r_cnt_in) && (w_rd.rate == r_rate_in);
        w_early  = $signed(r_time) < $signed(w_rd.tim);
        w_add_ok = !w_dup && !w_early && (r_count != 8'(ctm_pkg::DEPTH));
        w_key    = (r_cmd == ctm_pkg::CMD_T2C) ? (w_rd.tim ^ ctm_pkg::SIGN_BIT) : w_rd.cnt;
        w_q      = (r_cmd == ctm_pkg::CMD_T2C) ? (r_qt ^ ctm_pkg::SIGN_BIT) : r_qc;
        w_brk    = (r_qc < r_prev) || ((r_qc > r_prev) && (r_qc < w_rd.cnt));
        w_diff   = r_qc - r_ent.cnt;
        w_a      = r_qt ^ ctm_pkg::SIGN_BIT;
        w_b      = r_ent.tim ^ ctm_pkg::SIGN_BIT;
        w_tb     = r_ent.tim ^ ctm_pkg::SIGN_BIT;
        w_d      = md_rsp.quot[63:0];
        w_ovf    = |md_rsp.quot[ctm_pkg::QW-1:64];
        if (!r_neg) begin
            w_conv = (w_ovf || (w_d > ~w_tb)) ? 64'hFFFF_FFFF_FFFF_FFFF : (w_tb + w_d);
        end else begin
            w_conv = (w_ovf || (w_d > w_tb)) ? 64'd0 : (w_tb - w_d);
        end
    end

    always_comb begin
        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = w_tail;
        mem_req.wr_data = '{tim: r_time, cnt: r_cnt_in, rate: r_rate_in};
        mem_req.rd_addr = r_oldest;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (i_cmd == ctm_pkg::CMD_ADD) && (i_anchor_rate != 32'd0)
                    && (r_count == 8'd0)) begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_data = '{tim: i_anchor_time, cnt: i_anchor_counter,
                                        rate: i_anchor_rate};
                end
                if (i_cmd == ctm_pkg::CMD_ADD) begin
                    mem_req.rd_addr = w_newest;
                end else if (i_cmd == ctm_pkg::CMD_READ) begin
                    mem_req.rd_addr = r_oldest + i_entry_index;
                end
            end
            S_ADD_CHK: mem_req.wr_en = w_add_ok;
            S_EXP:     mem_req.rd_addr = r_oldest + r_j + 7'd1;
            S_KEY0:    mem_req.rd_addr = w_newest;
            S_SCAN:    mem_req.rd_addr = r_oldest + r_j - 7'd1;
            default:   mem_req.rd_addr = r_oldest;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_done     <= 1'b0;
        r_md.start <= 1'b0;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_oldest <= '0;
            r_count  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd     <= ctm_pkg::t_cmd'(i_cmd);
                        r_time    <= i_anchor_time;
                        r_cnt_in  <= i_anchor_counter;
                        r_rate_in <= i_anchor_rate;
                        r_qc      <= i_query_counter;
                        r_qt      <= i_query_time;
                        r_j       <= '0;
                        r_status  <= ctm_pkg::ST_OK;
                        r_rtime   <= '0;
                        r_rcount  <= '0;
                        r_etime   <= '0;
                        r_ecount  <= '0;
                        r_erate   <= '0;
                        case (ctm_pkg::t_cmd'(i_cmd))
                            ctm_pkg::CMD_ADD: begin
                                if (i_anchor_rate == 32'd0) begin
                                    r_status <= ctm_pkg::ST_BAD_RATE;
                                    r_done   <= 1'b1;
                                end else if (r_count == 8'd0) begin
                                    r_count <= 8'd1;
                                    r_done  <= 1'b1;
                                end else begin
                                    r_state <= S_ADD_CHK;
                                end
                            end
                            ctm_pkg::CMD_EXPIRE: begin
                                if (r_count == 8'd0) begin
                                    r_status <= ctm_pkg::ST_EMPTY;
                                    r_done   <= 1'b1;
                                end else begin
                                    r_state <= S_EXP;
                                end
                            end
                            ctm_pkg::CMD_C2T, ctm_pkg::CMD_T2C: begin
                                if (r_count == 8'd0) begin
                                    r_status <= ctm_pkg::ST_EMPTY;
                                    r_done   <= 1'b1;
                                end else begin
                                    r_state <= S_KEY0;
                                end
                            end
                            ctm_pkg::CMD_CLEAR: begin
                                r_oldest <= '0;
                                r_count  <= '0;
                                r_done   <= 1'b1;
                            end
                            ctm_pkg::CMD_READ: begin
                                if ({1'b0, i_entry_index} >= r_count) begin
                                    r_status <= ctm_pkg::ST_BAD_INDEX;
                                    r_done   <= 1'b1;
                                end else begin
                                    r_state <= S_READ;
                                end
                            end
                            default: r_done <= 1'b1;
                        endcase
                    end
                end
                S_ADD_CHK: begin
                    if (w_dup) begin
                        r_status <= ctm_pkg::ST_OK;
                    end else if (w_early) begin
                        r_status <= ctm_pkg::ST_NOT_MONO;
                    end else if (r_count == 8'(ctm_pkg::DEPTH)) begin
                        r_status <= ctm_pkg::ST_FULL;
                    end else begin
                        r_count <= r_count + 8'd1;
                    end
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_EXP: begin
                    if (r_j == '0) begin
                        r_prev <= w_rd.cnt;
                        if (r_count == 8'd1) begin
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_j <= 7'd1;
                        end
                    end else if (w_brk) begin
                        r_oldest <= r_oldest + r_j - 7'd1;
                        r_count  <= r_count - {1'b0, r_j} + 8'd1;
                        r_done   <= 1'b1;
                        r_state  <= S_IDLE;
                    end else if ({1'b0, r_j} == r_count - 8'd1) begin
                        r_oldest <= r_oldest + r_j;
                        r_count  <= r_count - {1'b0, r_j};
                        r_done   <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_prev <= w_rd.cnt;
                        r_j    <= r_j + 7'd1;
                    end
                end
                S_KEY0: begin
                    r_ent <= w_rd;
                    if ((w_q <= w_key) || (r_count == 8'd1)) begin
                        r_state <= S_PREP;
                    end else begin
                        r_j     <= ctm_pkg::AW'(r_count - 8'd1);
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_key <= w_q) begin
                        r_ent   <= w_rd;
                        r_state <= S_PREP;
                    end else if (r_j == 7'd1) begin
                        r_state <= S_PREP;
                    end else begin
                        r_j <= r_j - 7'd1;
                    end
                end
                S_PREP: begin
                    r_md.start <= 1'b1;
                    if (r_cmd == ctm_pkg::CMD_C2T) begin
                        r_neg    <= w_diff[63];
                        r_md.shr <= 1'b0;
                        r_md.mag <= w_diff[63] ? (64'd0 - w_diff) : w_diff;
                        r_md.mul <= UNITS;
                        r_md.div <= (r_ent.rate == 32'd0) ? 32'd1 : r_ent.rate;
                    end else begin
                        r_neg    <= w_a < w_b;
                        r_md.shr <= 1'b1;
                        r_md.mag <= (w_a < w_b) ? (w_b - w_a) : (w_a - w_b);
                        r_md.mul <= r_ent.rate;
                        r_md.div <= UNITS;
                    end
                    r_state <= S_MDW;
                end
                S_MDW: begin
                    if (md_rsp.done) begin
                        if (r_cmd == ctm_pkg::CMD_C2T) begin
                            r_rtime <= w_conv ^ ctm_pkg::SIGN_BIT;
                        end else begin
                            r_rcount <= r_neg ? (r_ent.cnt - w_d) : (r_ent.cnt + w_d);
                        end
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_READ: begin
                    r_etime  <= w_rd.tim;
                    r_ecount <= w_rd.cnt;
                    r_erate  <= w_rd.rate;
                    r_done   <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy                = (r_state != S_IDLE);
    assign o_done              = r_done;
    assign o_status            = r_status;
    assign o_result_time       = r_rtime;
    assign o_result_counter    = r_rcount;
    assign o_entry_time_out    = r_etime;
    assign o_entry_counter_out = r_ecount;
    assign o_entry_rate_out    = r_erate;
    assign o_entry_count       = r_count;

`ifndef SYNTH
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("accepted request neither busy nor done");

    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_req.wr_en |-> (r_count < 8'(ctm_pkg::DEPTH)))
        else $error("table write with table full");

    a_md_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        md_rsp.done |-> (r_state == S_MDW))
        else $error("divider finished outside wait state");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count <= 8'(ctm_pkg::DEPTH)))
        else $error("entry count beyond depth");
`endif

endmodule

// File: verif/ctm_checker.sv
// Checker for the counter/time map table: predicts every result and compares it.
module ctm_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [2:0]         i_cmd,
    input  logic signed [63:0] i_anchor_time,
    input  logic [63:0]        i_anchor_counter,
    input  logic [31:0]        i_anchor_rate,
    input  logic [63:0]        i_query_counter,
    input  logic signed [63:0] i_query_time,
    input  logic [6:0]         i_entry_index,
    input  logic               o_done,
    input  logic [2:0]         o_status,
    input  logic signed [63:0] o_result_time,
    input  logic [63:0]        o_result_counter,
    input  logic signed [63:0] o_entry_time_out,
    input  logic [63:0]        o_entry_counter_out,
    input  logic [31:0]        o_entry_rate_out,
    input  logic [7:0]         o_entry_count,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_ok_conv
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] rtime;
        logic [63:0] rcount;
        logic [63:0] etime;
        logic [63:0] ecount;
        logic [31:0] erate;
        logic [7:0]  count;
    } t_map_result;

    logic [63:0] anchor_time_q [ctm_pkg::DEPTH];
    logic [63:0] anchor_cnt_q [ctm_pkg::DEPTH];
    logic [31:0] anchor_rate_q [ctm_pkg::DEPTH];
    int unsigned head_pos;
    int unsigned fill;
    t_map_result expected_results [$];

    function automatic int unsigned pos_of(int unsigned k);
        return (head_pos + k) % ctm_pkg::DEPTH;
    endfunction

    function automatic logic [63:0] key_at(bit by_time, int unsigned k);
        return by_time ? (anchor_time_q[pos_of(k)] ^ ctm_pkg::SIGN_BIT)
                       : anchor_cnt_q[pos_of(k)];
    endfunction

    function automatic int unsigned pick_anchor(bit by_time, logic [63:0] q);
        if (q <= key_at(by_time, 0)) return 0;
        if (q >= key_at(by_time, fill - 1)) return fill - 1;
        for (int unsigned i = fill - 1; i > 0; i--)
            if (key_at(by_time, i) <= q) return i;
        return 0;
    endfunction

    function automatic logic [63:0] count_to_stamp(int unsigned s, logic [63:0] q);
        logic [63:0] rate, diff, mag, d, tb;
        logic [127:0] prod;
        bit neg, ovf;
        rate = (anchor_rate_q[s] != 0) ? {32'd0, anchor_rate_q[s]} : 64'd1;
        diff = q - anchor_cnt_q[s];
        neg = diff[63];
        mag = neg ? -diff : diff;
        prod = ({64'd0, mag} * ctm_pkg::UNITS_PER_SECOND) / rate;
        ovf = prod[127:64] != 0;
        d = prod[63:0];
        tb = anchor_time_q[s] ^ ctm_pkg::SIGN_BIT;
        if (!neg) tb = (ovf || d > ~tb) ? '1 : tb + d;
        else tb = (ovf || d > tb) ? '0 : tb - d;
        return tb ^ ctm_pkg::SIGN_BIT;
    endfunction

    function automatic logic [63:0] stamp_to_count(int unsigned s, logic [63:0] t);
        logic [63:0] a, b, mag, cnt;
        a = t ^ ctm_pkg::SIGN_BIT;
        b = anchor_time_q[s] ^ ctm_pkg::SIGN_BIT;
        mag = (a < b) ? b - a : a - b;
        cnt = (mag / ctm_pkg::UNITS_PER_SECOND) * anchor_rate_q[s]
            + ((mag % ctm_pkg::UNITS_PER_SECOND) * anchor_rate_q[s])
              / ctm_pkg::UNITS_PER_SECOND;
        return (a < b) ? anchor_cnt_q[s] - cnt : anchor_cnt_q[s] + cnt;
    endfunction

    task automatic predict_request();
        t_map_result r;
        int unsigned s, k;
        r = '0;
        case (i_cmd)
            ctm_pkg::CMD_ADD: begin
                if (i_anchor_rate == 0) begin
                    r.status = ctm_pkg::ST_BAD_RATE;
                end else begin
                    bit dup;
                    dup = 0;
                    if (fill > 0) begin
                        s = pos_of(fill - 1);
                        if (anchor_time_q[s] == i_anchor_time
                                && anchor_cnt_q[s] == i_anchor_counter
                                && anchor_rate_q[s] == i_anchor_rate)
                            dup = 1;
                        else if ((i_anchor_time ^ ctm_pkg::SIGN_BIT)
                                 < (anchor_time_q[s] ^ ctm_pkg::SIGN_BIT))
                            r.status = ctm_pkg::ST_NOT_MONO;
                    end
                    if (!dup && r.status == ctm_pkg::ST_OK) begin
                        if (fill >= ctm_pkg::DEPTH) begin
                            r.status = ctm_pkg::ST_FULL;
                        end else begin
                            s = pos_of(fill);
                            anchor_time_q[s] = i_anchor_time;
                            anchor_cnt_q[s] = i_anchor_counter;
                            anchor_rate_q[s] = i_anchor_rate;
                            fill++;
                        end
                    end
                end
            end
            ctm_pkg::CMD_EXPIRE: begin
                if (fill == 0) begin
                    r.status = ctm_pkg::ST_EMPTY;
                end else begin
                    k = 0;
                    while (k + 1 < fill) begin
                        logic [63:0] c, cn;
                        c = anchor_cnt_q[pos_of(k)];
                        cn = anchor_cnt_q[pos_of(k + 1)];
                        if (i_query_counter < c) break;
                        if (i_query_counter > c && i_query_counter < cn) break;
                        k++;
                    end
                    head_pos = pos_of(k);
                    fill -= k;
                end
            end
            ctm_pkg::CMD_C2T: begin
                if (fill == 0) r.status = ctm_pkg::ST_EMPTY;
                else begin
                    r.rtime = count_to_stamp(pos_of(pick_anchor(0, i_query_counter)),
                                             i_query_counter);
                    o_ok_conv++;
                end
            end
            ctm_pkg::CMD_T2C: begin
                if (fill == 0) r.status = ctm_pkg::ST_EMPTY;
                else begin
                    r.rcount = stamp_to_count(
                        pos_of(pick_anchor(1, i_query_time ^ ctm_pkg::SIGN_BIT)),
                        i_query_time);
                    o_ok_conv++;
                end
            end
            ctm_pkg::CMD_CLEAR: begin
                head_pos = 0;
                fill = 0;
            end
            ctm_pkg::CMD_READ: begin
                if (i_entry_index >= fill) r.status = ctm_pkg::ST_BAD_INDEX;
                else begin
                    s = pos_of(i_entry_index);
                    r.etime = anchor_time_q[s];
                    r.ecount = anchor_cnt_q[s];
                    r.erate = anchor_rate_q[s];
                end
            end
            default: ;
        endcase
        r.count = fill[7:0];
        expected_results.push_back(r);
    endtask

    task automatic check_result();
        t_map_result exp_r, got;
        got = {o_status, o_result_time, o_result_counter, o_entry_time_out,
               o_entry_counter_out, o_entry_rate_out, o_entry_count};
        if (expected_results.size() == 0) begin
            o_fail_count++;
            if (o_fail_count <= 10) $display("unexpected result: %h", got);
            return;
        end
        exp_r = expected_results.pop_front();
        if (got !== exp_r) begin
            o_fail_count++;
            if (o_fail_count <= 10)
                $display({"result mismatch: st %0d/%0d time %h/%h cnt %h/%h",
                          " entry %h %h %h / %h %h %h n %0d/%0d"},
                    exp_r.status, got.status, exp_r.rtime, got.rtime,
                    exp_r.rcount, got.rcount,
                    exp_r.etime, exp_r.ecount, exp_r.erate,
                    got.etime, got.ecount, got.erate,
                    exp_r.count, got.count);
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_ok_conv = 0;
        head_pos = 0;
        fill = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            head_pos = 0;
            fill = 0;
        end else begin
            if (o_done) check_result();
            if (start && !busy) predict_request();
        end
        o_pending = expected_results.size();
    end
endmodule

// File: verif/tb_counter_time_map_table_unit.sv
// Testbench top: drives requests into the counter/time map table and reports the verdict.
module tb_counter_time_map_table_unit;
    timeunit 1ns;
    timeprecision 1ps;

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               start = 0;
    logic [2:0]         i_cmd = ctm_pkg::CMD_CLEAR;
    logic signed [63:0] i_anchor_time = 0;
    logic [63:0]        i_anchor_counter = 0;
    logic [31:0]        i_anchor_rate = 0;
    logic [63:0]        i_query_counter = 0;
    logic signed [63:0] i_query_time = 0;
    logic [6:0]         i_entry_index = 0;
    logic               busy, o_done;
    logic [2:0]         o_status;
    logic signed [63:0] o_result_time, o_entry_time_out;
    logic [63:0]        o_result_counter, o_entry_counter_out;
    logic [31:0]        o_entry_rate_out;
    logic [7:0]         o_entry_count;
    int                 fail_count, pending, ok_conv;
    int                 cycle_count = 0;
    int                 sent = 0;
    logic signed [63:0] last_time = 0;
    logic [63:0]        last_cnt = 0;

    always #6 i_clk = ~i_clk;

    counter_time_map_table_unit DUT (.*);

    ctm_checker u_checker (
        .*,
        .o_fail_count(fail_count),
        .o_pending(pending),
        .o_ok_conv(ok_conv)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] edge64();
        case ($urandom_range(0, 5))
            0: return 64'h8000_0000_0000_0000;
            1: return 64'h7FFF_FFFF_FFFF_FFFF;
            2: return '0;
            3: return '1;
            default: return rand64();
        endcase
    endfunction

    task automatic issue(logic [2:0] cmd, logic [63:0] at, logic [63:0] ac, logic [31:0] ar,
                         logic [63:0] qc, logic [63:0] qt, logic [6:0] idx, bit idle);
        if (idle && $urandom_range(0, 99) < 13) begin
            start <= 0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_cmd <= cmd;
        i_anchor_time <= at;
        i_anchor_counter <= ac;
        i_anchor_rate <= ar;
        i_query_counter <= qc;
        i_query_time <= qt;
        i_entry_index <= idx;
        start <= 1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic add_next(bit idle);
        logic [63:0] dt;
        dt = (last_time > 64'sh7000_0000_0000_0000) ? 0 : $urandom_range(0, 1 << 30) * 64;
        last_time = last_time + dt;
        last_cnt = last_cnt + $urandom_range(0, 1 << 20);
        issue(ctm_pkg::CMD_ADD, last_time, last_cnt, $urandom_range(1, 100000000), 0, 0, 0,
              idle);
    endtask

    initial begin
        logic [63:0] q;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        // empty table cases, then directed adds, conversions at the edges, reads and unused codes
        issue(ctm_pkg::CMD_EXPIRE, 0, 0, 0, 5, 0, 0, 0);
        issue(ctm_pkg::CMD_C2T, 0, 0, 0, '1, 0, 0, 0);
        issue(ctm_pkg::CMD_T2C, 0, 0, 0, 0, 64'h8000_0000_0000_0000, 0, 0);
        issue(ctm_pkg::CMD_READ, 0, 0, 0, 0, 0, 7'h7F, 0);
        issue(ctm_pkg::CMD_ADD, 0, 0, 0, 0, 0, 0, 0);
        issue(ctm_pkg::CMD_ADD, 64'h8000_0000_0000_0000, 0, 32'hFFFF_FFFF, 0, 0, 0, 0);
        issue(ctm_pkg::CMD_ADD, 64'h8000_0000_0000_0000, 0, 32'hFFFF_FFFF, 0, 0, 0, 0);
        issue(ctm_pkg::CMD_ADD, 0, '1, 1, 0, 0, 0, 0);
        issue(ctm_pkg::CMD_ADD, -5, 7, 3, 0, 0, 0, 0);
        issue(ctm_pkg::CMD_ADD, 64'h7FFF_FFFF_FFFF_FFFF, 64'h10, 1, 0, 0, 0, 0);
        issue(ctm_pkg::CMD_C2T, 0, 0, 0, '1, 0, 0, 0);
        issue(ctm_pkg::CMD_C2T, 0, 0, 0, 64'h8000_0000_0000_0000, 0, 0, 0);
        issue(ctm_pkg::CMD_C2T, 0, 0, 0, 0, 0, 0, 0);
        issue(ctm_pkg::CMD_T2C, 0, 0, 0, 0, 64'h7FFF_FFFF_FFFF_FFFF, 0, 0);
        issue(ctm_pkg::CMD_T2C, 0, 0, 0, 0, 64'h8000_0000_0000_0000, 0, 0);
        issue(ctm_pkg::CMD_T2C, 0, 0, 0, 0, 64'd1 << 40, 0, 0);
        issue(ctm_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0);
        issue(ctm_pkg::CMD_READ, 0, 0, 0, 0, 0, 2, 0);
        issue(3'd6, '1, '1, '1, '1, '1, '1, 0);
        issue(3'd7, 0, 0, 0, 0, 0, 0, 0);
        issue(ctm_pkg::CMD_EXPIRE, 0, 0, 0, '1, 0, 0, 0);
        issue(ctm_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0);
        // fill to overflow
        last_time = 64'sh8000_0000_0000_0000;
        last_cnt = 0;
        repeat (130) add_next(0);
        issue(ctm_pkg::CMD_READ, 0, 0, 0, 0, 0, 127, 0);
        issue(ctm_pkg::CMD_EXPIRE, 0, 0, 0, last_cnt >> 1, 0, 0, 0);
        while (sent < 1850) begin
            bit idle;
            idle = sent > 600 && sent < 900 ? 0 : 1;
            case ($urandom_range(0, 19))
                0: issue(ctm_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, idle);
                1: begin
                    q = last_cnt - $urandom_range(0, 1 << 24);
                    issue(ctm_pkg::CMD_EXPIRE, 0, 0, 0,
                          $urandom_range(0, 3) == 0 ? edge64() : q, 0, 0, idle);
                end
                2, 3, 4: issue(ctm_pkg::CMD_C2T, 0, 0, 0,
                    $urandom_range(0, 3) == 0 ? edge64() : last_cnt - $urandom_range(0, 1 << 22),
                    0, 0, idle);
                5, 6, 7: issue(ctm_pkg::CMD_T2C, 0, 0, 0, 0,
                    $urandom_range(0, 3) == 0 ? edge64() : last_time - rand64() % (64'd1 << 40),
                    0, idle);
                8, 9: issue(ctm_pkg::CMD_READ, 0, 0, 0, 0, 0, 7'($urandom_range(0, 127)), idle);
                10: issue(ctm_pkg::CMD_ADD, edge64(), edge64(),
                          $urandom_range(0, 3) == 0 ? 0 : $urandom, 0, 0, 0, idle);
                11: issue(3'($urandom_range(0, 7)), rand64(), rand64(), $urandom, rand64(),
                          rand64(), 7'($urandom_range(0, 127)), idle);
                default: add_next(idle);
            endcase
            if ($urandom_range(0, 39) == 0) begin
                last_time = 64'sh8000_0000_0000_0000 + rand64() % (64'd1 << 50);
                last_cnt = rand64();
                issue(ctm_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, idle);
            end
        end
        start <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("Sent %0d requests: adds up to a full table, expires, clears, reads, and", sent);
        $display("%0d conversions with data in both directions.", ok_conv);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
